### rtl/core/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, widths and helpers for the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  // element and result width, Q1.14 codes
  localparam int W = 16;
  // square root argument width (unsigned, clamped at zero)
  localparam int ARG_W = 17;
  // off-diagonal sum or difference width
  localparam int D_W = 17;
  // radicand width: argument shifted by the fraction bits
  localparam int RAD_W = 31;
  // root width
  localparam int ROOT_W = 16;
  // quotient bits kept before clipping
  localparam int QUO_W = 17;
  // Q14 unity
  localparam logic signed [18:0] Q_ONE = 19'sd16384;
  // saturation bounds
  localparam logic signed [18:0] SAT_HI = 19'sd32767;
  localparam logic signed [18:0] SAT_LO = -19'sd32768;

  // branch chosen by the classifier
  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  // one classified request: root argument and the three numerators
  typedef struct packed {
    branch_t                br;
    logic [ARG_W-1:0]       arg;
    logic signed [D_W-1:0]  d0;
    logic signed [D_W-1:0]  d1;
    logic signed [D_W-1:0]  d2;
  } mid_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic empty;
    mid_t head;
  } mid_q_t;

  // clip a wide signed value to 16 bits
  function automatic logic signed [W-1:0] sat16(input logic signed [18:0] v);
    logic signed [W-1:0] r;
    if (v > SAT_HI) r = 16'sh7fff;
    else if (v < SAT_LO) r = 16'sh8000;
    else r = v[W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Accepts matrices, picks the Shepperd branch and queues the classified request.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       push,
  output logic                      full,
  input  wire logic signed [15:0]   r00,
  input  wire logic signed [15:0]   r01,
  input  wire logic signed [15:0]   r02,
  input  wire logic signed [15:0]   r10,
  input  wire logic signed [15:0]   r11,
  input  wire logic signed [15:0]   r12,
  input  wire logic signed [15:0]   r20,
  input  wire logic signed [15:0]   r21,
  input  wire logic signed [15:0]   r22,
  output rmq_pkg::mid_q_t           mid_q,
  input  wire                       mid_pop
);

  logic signed [18:0] a00, a11, a22, tr, arg_s;
  logic signed [16:0] e01, e02, e10, e12, e20, e21;
  rmq_pkg::mid_t      cls;
  rmq_pkg::mid_t      mem [2];
  logic               wp, rp;
  logic [1:0]         cnt;
  logic               wr_en, rd_en;

  // widen the elements
  always_comb begin
    a00 = 19'(r00);
    a11 = 19'(r11);
    a22 = 19'(r22);
    e01 = 17'(r01);
    e02 = 17'(r02);
    e10 = 17'(r10);
    e12 = 17'(r12);
    e20 = 17'(r20);
    e21 = 17'(r21);
    tr  = a00 + a11 + a22;
  end

  // branch selection and numerators
  always_comb begin
    priority if (tr > 19'sd0) begin
      cls.br = rmq_pkg::BR_TRACE;
      arg_s  = rmq_pkg::Q_ONE + tr;
      cls.d0 = e21 - e12;
      cls.d1 = e02 - e20;
      cls.d2 = e10 - e01;
    end else if (r00 > r11 && r00 > r22) begin
      cls.br = rmq_pkg::BR_X;
      arg_s  = rmq_pkg::Q_ONE + a00 - a11 - a22;
      cls.d0 = e21 - e12;
      cls.d1 = e01 + e10;
      cls.d2 = e02 + e20;
    end else if (r11 > r22) begin
      cls.br = rmq_pkg::BR_Y;
      arg_s  = rmq_pkg::Q_ONE + a11 - a00 - a22;
      cls.d0 = e02 - e20;
      cls.d1 = e01 + e10;
      cls.d2 = e12 + e21;
    end else begin
      cls.br = rmq_pkg::BR_Z;
      arg_s  = rmq_pkg::Q_ONE + a22 - a00 - a11;
      cls.d0 = e10 - e01;
      cls.d1 = e02 + e20;
      cls.d2 = e12 + e21;
    end
    // negative argument only on non-rotation input: root of zero
    cls.arg = (arg_s < 19'sd0) ? '0 : arg_s[rmq_pkg::ARG_W-1:0];
  end

  // two-entry queue toward the back end
  assign full  = (cnt == 2'd2);
  assign wr_en = push && !full;
  assign rd_en = mid_pop && (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_en) wp <= ~wp;
      if (rd_en) rp <= ~rp;
      cnt <= cnt + 2'(wr_en) - 2'(rd_en);
    end
  end

  assign mid_q.empty = (cnt == 2'd0);
  assign mid_q.head  = mem[rp];

endmodule

`default_nettype wire

### rtl/core/rmq_back.sv
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined square root, three pipelined dividers, remap and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_back (
  input  wire                       clk,
  input  wire                       rst,
  input  wire rmq_pkg::mid_q_t      mid_q,
  output logic                      mid_pop,
  output logic                      empty,
  input  wire                       pop,
  output logic signed [15:0]        quat_x,
  output logic signed [15:0]        quat_y,
  output logic signed [15:0]        quat_z,
  output logic signed [15:0]        quat_w
);

  localparam int SQ_N = rmq_pkg::ROOT_W;
  localparam int DV_N = rmq_pkg::QUO_W;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] w;
  } out_t;

  // square root stages
  logic                             sq_v    [SQ_N+1];
  logic [rmq_pkg::RAD_W-1:0]        sq_rem  [SQ_N+1];
  logic [rmq_pkg::ROOT_W-1:0]       sq_root [SQ_N+1];
  rmq_pkg::branch_t                 sq_br   [SQ_N+1];
  logic signed [rmq_pkg::D_W-1:0]   sq_d    [SQ_N+1][3];
  logic [rmq_pkg::RAD_W-1:0]        sq_rem_n  [SQ_N+1];
  logic [rmq_pkg::ROOT_W-1:0]       sq_root_n [SQ_N+1];

  // divider stages
  logic                             dv_v    [DV_N+1];
  rmq_pkg::branch_t                 dv_br   [DV_N+1];
  logic [rmq_pkg::ROOT_W-1:0]       dv_r    [DV_N+1];
  logic [rmq_pkg::RAD_W-1:0]        dv_rem  [DV_N+1][3];
  logic [rmq_pkg::QUO_W-1:0]        dv_q    [DV_N+1][3];
  logic                             dv_neg  [DV_N+1][3];
  logic                             dv_ovf  [DV_N+1][3];
  logic [rmq_pkg::RAD_W-1:0]        dv_rem_n [DV_N+1][3];
  logic [rmq_pkg::QUO_W-1:0]        dv_q_n   [DV_N+1][3];

  // setup of the dividers from the root
  logic [rmq_pkg::RAD_W-1:0]        set_num [3];
  logic [rmq_pkg::D_W-1:0]          set_mag [3];
  logic                             set_ovf [3];

  logic       en;
  out_t       ofmt;
  out_t       omem [2];
  logic       owp, orp;
  logic [1:0] ocnt;
  logic       o_wr, o_rd;

  // pipeline advances unless the result queue is full and not drained
  assign en      = (ocnt != 2'd2) || pop;
  assign mid_pop = en && !mid_q.empty;

  // root: one result bit per stage
  always_comb begin
    logic [31:0] t;
    int i;
    sq_rem_n[0]  = '0;
    sq_root_n[0] = '0;
    for (int k = 1; k <= SQ_N; k++) begin
      i = SQ_N - k;
      t = (32'(sq_root[k-1]) << (i + 1)) | (32'd1 << (2 * i));
      if (32'(sq_rem[k-1]) >= t) begin
        sq_rem_n[k]  = sq_rem[k-1] - t[rmq_pkg::RAD_W-1:0];
        sq_root_n[k] = sq_root[k-1] | (rmq_pkg::ROOT_W'(1) << i);
      end else begin
        sq_rem_n[k]  = sq_rem[k-1];
        sq_root_n[k] = sq_root[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQ_N; k++) sq_v[k] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= !mid_q.empty;
      for (int k = 1; k <= SQ_N; k++) sq_v[k] <= sq_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= {mid_q.head.arg, 14'd0};
      sq_root[0] <= '0;
      sq_br[0]   <= mid_q.head.br;
      sq_d[0][0] <= mid_q.head.d0;
      sq_d[0][1] <= mid_q.head.d1;
      sq_d[0][2] <= mid_q.head.d2;
      for (int k = 1; k <= SQ_N; k++) begin
        sq_rem[k]  <= sq_rem_n[k];
        sq_root[k] <= sq_root_n[k];
        sq_br[k]   <= sq_br[k-1];
        for (int j = 0; j < 3; j++) sq_d[k][j] <= sq_d[k-1][j];
      end
    end
  end

  // divider setup: numerator |d|*2^14 + R over 2R, rounded half away
  always_comb begin
    logic [rmq_pkg::ROOT_W:0] den;
    den = {sq_root[SQ_N], 1'b0};
    for (int j = 0; j < 3; j++) begin
      set_mag[j] = sq_d[SQ_N][j][rmq_pkg::D_W-1] ? 17'(-sq_d[SQ_N][j]) : sq_d[SQ_N][j];
      set_num[j] = {set_mag[j][16:0], 14'd0} + 31'(sq_root[SQ_N]);
      if (sq_root[SQ_N] == '0) begin
        set_ovf[j] = (sq_d[SQ_N][j] != '0);
      end else begin
        set_ovf[j] = 34'(set_num[j]) >= (34'(den) << DV_N);
      end
    end
  end

  // quotient: one bit per stage
  always_comb begin
    logic [33:0] ds;
    int i;
    for (int j = 0; j < 3; j++) begin
      dv_rem_n[0][j] = '0;
      dv_q_n[0][j]   = '0;
    end
    for (int k = 1; k <= DV_N; k++) begin
      i = DV_N - k;
      for (int j = 0; j < 3; j++) begin
        ds = 34'({dv_r[k-1], 1'b0}) << i;
        dv_rem_n[k][j] = dv_rem[k-1][j];
        dv_q_n[k][j]   = dv_q[k-1][j];
        if (34'(dv_rem[k-1][j]) >= ds) begin
          dv_rem_n[k][j] = dv_rem[k-1][j] - ds[rmq_pkg::RAD_W-1:0];
          dv_q_n[k][j][i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DV_N; k++) dv_v[k] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SQ_N];
      for (int k = 1; k <= DV_N; k++) dv_v[k] <= dv_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_br[0] <= sq_br[SQ_N];
      dv_r[0]  <= sq_root[SQ_N];
      for (int j = 0; j < 3; j++) begin
        dv_rem[0][j] <= set_num[j];
        dv_q[0][j]   <= '0;
        dv_neg[0][j] <= sq_d[SQ_N][j][rmq_pkg::D_W-1];
        dv_ovf[0][j] <= set_ovf[j];
      end
      for (int k = 1; k <= DV_N; k++) begin
        dv_br[k] <= dv_br[k-1];
        dv_r[k]  <= dv_r[k-1];
        for (int j = 0; j < 3; j++) begin
          dv_rem[k][j] <= dv_rem_n[k][j];
          dv_q[k][j]   <= dv_q_n[k][j];
          dv_neg[k][j] <= dv_neg[k-1][j];
          dv_ovf[k][j] <= dv_ovf[k-1][j];
        end
      end
    end
  end

  // remap to the left-handed frame and saturate
  always_comb begin
    logic signed [18:0] h, qw, qx, qy, qz;
    logic signed [18:0] c [3];
    logic [16:0] m;
    h = 19'(({1'b0, dv_r[DV_N]} + 17'd1) >> 1);
    for (int j = 0; j < 3; j++) begin
      m = dv_ovf[DV_N][j] ? 17'h1ffff : dv_q[DV_N][j];
      c[j] = dv_neg[DV_N][j] ? -19'($unsigned(m)) : 19'($unsigned(m));
    end
    unique case (dv_br[DV_N])
      rmq_pkg::BR_TRACE: begin qw = h;    qx = c[0]; qy = c[1]; qz = c[2]; end
      rmq_pkg::BR_X:     begin qw = c[0]; qx = h;    qy = c[1]; qz = c[2]; end
      rmq_pkg::BR_Y:     begin qw = c[0]; qx = c[1]; qy = h;    qz = c[2]; end
      default:           begin qw = c[0]; qx = c[1]; qy = c[2]; qz = h;    end
    endcase
    ofmt.x = rmq_pkg::sat16(-qz);
    ofmt.y = rmq_pkg::sat16(qx);
    ofmt.z = rmq_pkg::sat16(qy);
    ofmt.w = rmq_pkg::sat16(-qw);
  end

  // two-entry result queue
  assign o_wr  = en && dv_v[DV_N];
  assign o_rd  = pop && (ocnt != 2'd0);
  assign empty = (ocnt == 2'd0);

  always_ff @(posedge clk) begin
    if (o_wr) begin
      omem[owp] <= ofmt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (o_wr) owp <= ~owp;
      if (o_rd) orp <= ~orp;
      ocnt <= ocnt + 2'(o_wr) - 2'(o_rd);
    end
  end

  assign quat_x = omem[orp].x;
  assign quat_y = omem[orp].y;
  assign quat_z = omem[orp].z;
  assign quat_w = omem[orp].w;

endmodule

`default_nettype wire

### rtl/core/rotation_matrix_to_quaternion_unit.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Shepperd rotation matrix to quaternion conversion in Q1.14, remapped frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel is a queue: drive r00..r22 and raise push; a request is
//   taken on a clock edge with push high and full low.
//   Result channel is a queue: while empty is low the oldest result sits on
//   quat_x..quat_w; it is taken on a clock edge with pop high.
//   Throughput: one request per cycle, sustained, for any mix of branches,
//   while the receiver keeps popping results. An accepted request passes the
//   request queue, 17 root stages (load plus 16 result bits) and 18 divider
//   stages (setup plus 17 quotient bits) before empty goes low.
//   When the receiver stalls, the result queue fills, the pipeline holds its
//   contents, then the input queue fills and full rises; nothing is lost.
//   Synchronous reset empties both queues and the pipeline; no clearing
//   pass is needed and a request may be pushed in the first cycle after.
//   Degenerate input yields saturated components, never an error.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_unit (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       push,
  output logic                      full,
  input  wire logic signed [15:0]   r00,
  input  wire logic signed [15:0]   r01,
  input  wire logic signed [15:0]   r02,
  input  wire logic signed [15:0]   r10,
  input  wire logic signed [15:0]   r11,
  input  wire logic signed [15:0]   r12,
  input  wire logic signed [15:0]   r20,
  input  wire logic signed [15:0]   r21,
  input  wire logic signed [15:0]   r22,
  output logic                      empty,
  input  wire                       pop,
  output logic signed [15:0]        quat_x,
  output logic signed [15:0]        quat_y,
  output logic signed [15:0]        quat_z,
  output logic signed [15:0]        quat_w
);

  rmq_pkg::mid_q_t mid_q;
  logic            mid_pop;

  // classifier and request queue
  rmq_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .r00     (r00),
    .r01     (r01),
    .r02     (r02),
    .r10     (r10),
    .r11     (r11),
    .r12     (r12),
    .r20     (r20),
    .r21     (r21),
    .r22     (r22),
    .mid_q   (mid_q),
    .mid_pop (mid_pop)
  );

  // arithmetic pipeline and result queue
  rmq_back u_back (
    .clk     (clk),
    .rst     (rst),
    .mid_q   (mid_q),
    .mid_pop (mid_pop),
    .empty   (empty),
    .pop     (pop),
    .quat_x  (quat_x),
    .quat_y  (quat_y),
    .quat_z  (quat_z),
    .quat_w  (quat_w)
  );

`ifndef SYNTHESIS
  // the back end never draws from an empty request queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    mid_q.empty |-> !mid_pop) else $error("request queue popped while empty");

  // reset leaves both sides empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full)) else $error("queues not empty after reset");

  // a full request queue cannot drain while the back end does not pop
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (full && !mid_pop) |=> full) else $error("request queue lost an entry");
`endif

endmodule

`default_nettype wire
